/* design/cbe_pkg.sv */
package cbe_pkg;

    // Command codes
    localparam logic [2:0] OP_HEAD    = 3'd0;
    localparam logic [2:0] OP_SINT    = 3'd1;
    localparam logic [2:0] OP_RAW     = 3'd2;
    localparam logic [2:0] OP_STRING  = 3'd3;
    localparam logic [2:0] OP_PAYLOAD = 3'd4;
    localparam logic [2:0] OP_REWIND  = 3'd5;

    // Additional-info codes for the long head forms
    localparam logic [4:0] INFO_MAX_DIRECT = 5'd23;
    localparam logic [4:0] INFO_U8         = 5'd24;
    localparam logic [4:0] INFO_U16        = 5'd25;
    localparam logic [4:0] INFO_U32        = 5'd26;

    localparam logic [2:0] MAJOR_UINT    = 3'd0;
    localparam logic [2:0] MAJOR_NINT    = 3'd1;
    localparam logic [2:0] MAJOR_INVALID = 3'd7;

    localparam int MAX_BYTES   = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // One command after classification: what the back end has to stream out
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;     // byte k goes out k-th
        logic [2:0]                count;     // 1 to 5 beats
        logic                      writes;    // beats carry a written byte
        logic                      accepted;
        logic [15:0]               base;      // fill level before the command (zero for a rewind)
    } cbe_cmd_t;

endpackage

/* design/cbe_front.sv */
module cbe_front
    import cbe_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [15:0]       cfg_data,
    input  logic              push,
    input  logic              queue_full,
    input  logic [2:0]        operation,
    input  logic [2:0]        major_type,
    input  logic [31:0]       argument,
    input  logic signed [31:0] signed_value,
    input  logic [4:0]        head_info,
    input  logic [7:0]        payload_byte,
    output logic              cmd_write,
    output cbe_cmd_t          cmd
);

    localparam int SPACE_BITS = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    logic [15:0]              capacity_reg;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [15:0]              payload_left_reg, payload_left_next;
    logic                     payload_open_reg, payload_open_next;

    logic [SPACE_BITS-1:0] cap_w, pos_w, space;
    logic [33:0]           space_ext;
    logic [31:0]           h_arg;
    logic [2:0]            h_major;
    logic [2:0]            h_size;
    logic [MAX_BYTES-1:0][7:0] h_bytes;
    logic                  fits;
    logic [15:0]           left_dec;

    function automatic logic [2:0] head_size(input logic [31:0] a);
        if (a <= 32'(INFO_MAX_DIRECT)) return 3'd1;
        if (a <= 32'h0000_00FF)        return 3'd2;
        if (a <= 32'h0000_FFFF)        return 3'd3;
        return 3'd5;
    endfunction

    assign cmd_write = push && !queue_full;

    assign cap_w     = SPACE_BITS'(capacity_reg);
    assign pos_w     = SPACE_BITS'(position_reg);
    assign space     = (cap_w > pos_w) ? (cap_w - pos_w) : '0;
    assign space_ext = 34'(space);
    assign left_dec  = payload_left_reg - 16'd1;

    // Pick head major type and argument; a negative integer encodes -1-value
    always_comb
    begin
        if (operation == OP_SINT) begin
            h_arg   = signed_value[31] ? ~signed_value : signed_value;
            h_major = signed_value[31] ? MAJOR_NINT : MAJOR_UINT;
        end else begin
            h_arg   = argument;
            h_major = major_type;
        end
        h_size  = head_size(h_arg);
        h_bytes = '0;
        case (h_size)
            3'd1: h_bytes[0] = {h_major, h_arg[4:0]};
            3'd2:
            begin
                h_bytes[0] = {h_major, INFO_U8};
                h_bytes[1] = h_arg[7:0];
            end
            3'd3:
            begin
                h_bytes[0] = {h_major, INFO_U16};
                h_bytes[1] = h_arg[15:8];
                h_bytes[2] = h_arg[7:0];
            end
            default:
            begin
                h_bytes[0] = {h_major, INFO_U32};
                h_bytes[1] = h_arg[31:24];
                h_bytes[2] = h_arg[23:16];
                h_bytes[3] = h_arg[15:8];
                h_bytes[4] = h_arg[7:0];
            end
        endcase
    end

    // Classify the command and work out the state it leaves
    always_comb
    begin
        cmd               = '0;
        cmd.count         = 3'd1;
        cmd.base          = 16'(position_reg);
        fits              = 1'b0;
        position_next     = position_reg;
        payload_left_next = payload_left_reg;
        payload_open_next = payload_open_reg;

        case (operation)
            OP_HEAD, OP_SINT:
            begin
                payload_open_next = 1'b0;
                payload_left_next = '0;
                fits = ((operation == OP_SINT) || (major_type != MAJOR_INVALID))
                       && (34'(h_size) <= space_ext);
                if (fits) begin
                    cmd.bytes = h_bytes;
                    cmd.count = h_size;
                end
            end
            OP_STRING:
            begin
                payload_open_next = 1'b0;
                payload_left_next = '0;
                fits = (major_type != MAJOR_INVALID)
                       && ((34'(h_size) + 34'(argument)) <= space_ext);
                if (fits) begin
                    cmd.bytes = h_bytes;
                    cmd.count = h_size;
                    if (argument != 32'd0) begin
                        payload_open_next = 1'b1;
                        payload_left_next = argument[15:0];
                    end
                end
            end
            OP_RAW:
            begin
                payload_open_next = 1'b0;
                payload_left_next = '0;
                fits = (space != '0);
                if (fits) begin
                    cmd.bytes[0] = {major_type, head_info};
                end
            end
            OP_PAYLOAD:
            begin
                fits = payload_open_reg && (payload_left_reg != 16'd0) && (space != '0);
                if (fits) begin
                    cmd.bytes[0]      = payload_byte;
                    payload_left_next = left_dec;
                    if (left_dec == 16'd0) begin
                        payload_open_next = 1'b0;
                    end
                end
            end
            OP_REWIND:
            begin
                payload_open_next = 1'b0;
                payload_left_next = '0;
                position_next     = '0;
                cmd.accepted      = 1'b1;
                cmd.base          = '0;
            end
            default:
            begin
                fits = 1'b0;
            end
        endcase

        if (fits) begin
            cmd.writes    = 1'b1;
            cmd.accepted  = 1'b1;
            position_next = position_reg + POSITION_BITS'(cmd.count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg     <= 16'd1024;
            position_reg     <= '0;
            payload_left_reg <= '0;
            payload_open_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                capacity_reg <= cfg_data;
            end
            if (cmd_write) begin
                position_reg     <= position_next;
                payload_left_reg <= payload_left_next;
                payload_open_reg <= payload_open_next;
            end
        end
    end

endmodule

/* design/cbe_queue.sv */
module cbe_queue
    import cbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  cbe_cmd_t wr_cmd,
    input  logic     rd_en,
    output logic     full,
    output logic     empty,
    output cbe_cmd_t rd_cmd
);

    cbe_cmd_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg, count_next;

    assign full   = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/cbe_back.sv */
module cbe_back
    import cbe_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  cbe_cmd_t    cmd,
    output logic        queue_pop,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        last,
    output logic        accepted,
    output logic [15:0] fill_level
);

    localparam logic [15:0] FILL_MASK = (POSITION_BITS >= 16) ? 16'hFFFF :
        16'((33'd1 << POSITION_BITS) - 33'd1);

    logic [2:0]  beat_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        byte_valid_reg, last_reg, accepted_reg;
    logic [15:0] fill_reg;

    logic        advance, load, final_beat;
    logic [2:0]  beat_inc;
    logic [15:0] fill_calc;

    assign advance    = !out_valid_reg || pop;
    assign load       = advance && !queue_empty;
    assign beat_inc   = beat_reg + 3'd1;
    assign final_beat = (beat_inc == cmd.count);
    assign queue_pop  = load && final_beat;
    assign fill_calc  = cmd.writes ? ((cmd.base + 16'(beat_inc)) & FILL_MASK) : cmd.base;

    assign empty      = !out_valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;
    assign accepted   = accepted_reg;
    assign fill_level = fill_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg       <= cmd.bytes[beat_reg];
            byte_valid_reg <= cmd.writes;
            last_reg       <= final_beat;
            accepted_reg   <= cmd.accepted;
            fill_reg       <= fill_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end else if (advance) begin
            out_valid_reg <= !queue_empty;
            if (load) begin
                beat_reg <= final_beat ? 3'd0 : beat_inc;
            end
        end
    end

endmodule

/* design/cbor_head_encoder_core.sv */
// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------------------
// input     push / full            operation, major_type, argument, signed_value,
//                                  head_info, payload_byte
// result    empty / pop            out_byte, byte_valid, last, accepted, fill_level
// config    cfg_write (no wait)    cfg_data -> capacity
//
// The front end classifies a command in the cycle it is pushed: fit check against
// the space left, head bytes, position and payload bookkeeping. It takes one
// command per cycle while the four-entry command queue has room.
// The back end streams one result beat per cycle, while its output register is
// empty or being popped, from the queue head; a command has 1 to 5 beats.
// Reset clears position, payload state and the queue, and sets capacity to 1024.
// A withheld pop stalls only the back end; the front keeps taking commands until the
// queue fills.
module cbor_head_encoder_core
    import cbe_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [15:0]       cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        operation,
    input  logic [2:0]        major_type,
    input  logic [31:0]       argument,
    input  logic signed [31:0] signed_value,
    input  logic [4:0]        head_info,
    input  logic [7:0]        payload_byte,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              last,
    output logic              accepted,
    output logic [15:0]       fill_level
);

    logic     cmd_write;
    cbe_cmd_t cmd_in;
    cbe_cmd_t cmd_head;
    logic     queue_full;
    logic     queue_empty;
    logic     queue_pop;

    // Hold off the producer only when the command queue is full
    assign full = queue_full;

    cbe_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .push         (push),
        .queue_full   (queue_full),
        .operation    (operation),
        .major_type   (major_type),
        .argument     (argument),
        .signed_value (signed_value),
        .head_info    (head_info),
        .payload_byte (payload_byte),
        .cmd_write    (cmd_write),
        .cmd          (cmd_in)
    );

    // Decouple classification from byte streaming
    cbe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_write),
        .wr_cmd (cmd_in),
        .rd_en  (queue_pop),
        .full   (queue_full),
        .empty  (queue_empty),
        .rd_cmd (cmd_head)
    );

    // Advance one beat per cycle while the output is free or popped; drop the queue entry after its last beat
    cbe_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .cmd         (cmd_head),
        .queue_pop   (queue_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .accepted    (accepted),
        .fill_level  (fill_level)
    );

endmodule
